// ===== design/sfm_pkg.sv =====
// shared types, constants and helpers for the spatial filter matrix mixer
// no dependencies
`default_nettype none

package sfm_pkg;

  localparam int MAX_IN_CHANNELS  = 16;
  localparam int MAX_OUT_CHANNELS = 16;

  localparam int CH_W      = 4;
  localparam int CH_NUM    = 2 ** CH_W;
  localparam int CNT_W     = 5;
  localparam int VAL_W     = 16;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int ACC_W     = 36;
  localparam int COEF_FRAC = 14;

  localparam int COEF_DEPTH = MAX_IN_CHANNELS * MAX_OUT_CHANNELS;
  localparam int ADDR_W     = $clog2(COEF_DEPTH);
  localparam int OUT_IDX_W  = $clog2(MAX_OUT_CHANNELS);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_USED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_USED = 1'b1;

  localparam logic FUNC_COEF   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [CNT_W-1:0] LIM_IN =
    CNT_W'((MAX_IN_CHANNELS < CH_NUM) ? MAX_IN_CHANNELS : CH_NUM);
  localparam logic [CNT_W-1:0] LIM_OUT =
    CNT_W'((MAX_OUT_CHANNELS < CH_NUM) ? MAX_OUT_CHANNELS : CH_NUM);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (VAL_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(2 ** (VAL_W - 1));

  typedef struct packed {
    logic                    func;
    logic [CH_W-1:0]         in_channel;
    logic [CH_W-1:0]         out_channel;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]         result_channel;
    logic signed [VAL_W-1:0] result_value;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    logic            coef_wr;
    logic            samp_ld;
    logic            rd_en;
    logic [CH_W-1:0] rd_idx;
    logic            emit_en;
    logic [CH_W-1:0] emit_idx;
    logic            emit_last;
    logic            acc_clr;
  } sfm_cmd_t;

  typedef struct packed {
    logic out_free;
  } sfm_sts_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] r,
                                                 input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] c;
    if (r == '0) begin
      c = CNT_W'(1);
    end else if (r > lim) begin
      c = lim;
    end else begin
      c = r;
    end
    return c;
  endfunction

  function automatic logic [ADDR_W-1:0] coef_addr(input logic [CH_W-1:0] ich,
                                                  input logic [CH_W-1:0] och);
    return ADDR_W'(ADDR_W'(ich) * ADDR_W'(MAX_OUT_CHANNELS) + ADDR_W'(och));
  endfunction

endpackage

`default_nettype wire

// ===== design/sfm_ram.sv =====
// generic simple dual port ram with registered read
// no dependencies
`default_nettype none

module sfm_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== design/sfm_ctrl.sv =====
// controller: configuration registers and the sequencer for load, mac and emit
// depends on sfm_pkg
`default_nettype none

module sfm_ctrl import sfm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data,
  input  wire sfm_sts_t             sts,
  output sfm_cmd_t                  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]       st_r, st_nxt;
  logic [CH_W-1:0]  cnt_r, cnt_nxt;
  logic             drn_r, drn_nxt;
  logic             fin_r, fin_nxt;
  logic [CNT_W-1:0] in_used_r, in_used_nxt;
  logic [CNT_W-1:0] out_used_r, out_used_nxt;

  logic [CNT_W-1:0] n_in;
  logic [CNT_W-1:0] n_out;
  logic             cnt_last;
  logic             acc_in;

  assign n_in     = eff_count(in_used_r, LIM_IN);
  assign n_out    = eff_count(out_used_r, LIM_OUT);
  assign cnt_last = ({1'b0, cnt_r} == CNT_W'(n_out - CNT_W'(1)));
  assign in_stall = (st_r != ST_IDLE);
  assign acc_in   = in_valid && !in_stall;

  always_comb begin
    in_used_nxt  = in_used_r;
    out_used_nxt = out_used_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_USED:  in_used_nxt  = cfg_data;
        CFG_OUT_USED: out_used_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    drn_nxt = drn_r;
    fin_nxt = fin_r;
    cmd     = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (acc_in) begin
          if (in_data.func == FUNC_COEF) begin
            cmd.coef_wr = (int'(in_data.in_channel) < MAX_IN_CHANNELS) &&
                          (int'(in_data.out_channel) < MAX_OUT_CHANNELS);
          end else if ({1'b0, in_data.in_channel} < n_in) begin
            cmd.samp_ld = 1'b1;
            st_nxt      = ST_MAC;
            cnt_nxt     = '0;
            fin_nxt     = ({1'b0, in_data.in_channel} == CNT_W'(n_in - CNT_W'(1)));
          end
        end
      end
      ST_MAC: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_idx = cnt_r;
        if (cnt_last) begin
          st_nxt  = ST_DRAIN;
          drn_nxt = 1'b0;
        end else begin
          cnt_nxt = CH_W'(cnt_r + CH_W'(1));
        end
      end
      ST_DRAIN: begin
        drn_nxt = 1'b1;
        if (drn_r) begin
          cnt_nxt = '0;
          st_nxt  = fin_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_en   = 1'b1;
          cmd.emit_idx  = cnt_r;
          cmd.emit_last = cnt_last;
          if (cnt_last) begin
            cmd.acc_clr = 1'b1;
            st_nxt      = ST_IDLE;
          end else begin
            cnt_nxt = CH_W'(cnt_r + CH_W'(1));
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      cnt_r      <= '0;
      drn_r      <= 1'b0;
      fin_r      <= 1'b0;
      in_used_r  <= CNT_W'(1);
      out_used_r <= CNT_W'(1);
    end else begin
      st_r       <= st_nxt;
      cnt_r      <= cnt_nxt;
      drn_r      <= drn_nxt;
      fin_r      <= fin_nxt;
      in_used_r  <= in_used_nxt;
      out_used_r <= out_used_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/sfm_dp.sv =====
// datapath: coefficient store, multiply-accumulate pipeline, accumulators, output register
// depends on sfm_pkg and sfm_ram
`default_nettype none

module sfm_dp import sfm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_word_t in_data,
  input  wire sfm_cmd_t cmd,
  output sfm_sts_t      sts,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_data
);

  logic signed [VAL_W-1:0]  samp_r;
  logic [CH_W-1:0]          ich_r;
  logic [COEF_DEPTH-1:0]    vld_r;
  logic                     ok_r;
  logic                     p1_vld_r;
  logic [CH_W-1:0]          p1_idx_r;
  logic                     p2_vld_r;
  logic [CH_W-1:0]          p2_idx_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r [MAX_OUT_CHANNELS];
  logic                     out_valid_r;
  out_word_t                out_r;

  logic [ADDR_W-1:0]       waddr;
  logic [ADDR_W-1:0]       raddr;
  logic [VAL_W-1:0]        rdata;
  logic signed [VAL_W-1:0] coef;
  logic signed [ACC_W-1:0] sel;
  logic signed [ACC_W-1:0] shr;
  logic signed [VAL_W-1:0] sat;

  assign waddr = coef_addr(in_data.in_channel, in_data.out_channel);
  assign raddr = coef_addr(ich_r, cmd.rd_idx);

  sfm_ram #(
    .W     (VAL_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (cmd.coef_wr),
    .waddr (waddr),
    .wdata (in_data.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entries never written read as zero
  assign coef = ok_r ? signed'(rdata) : '0;

  always_ff @(posedge clk) begin
    if (cmd.samp_ld) begin
      samp_r <= in_data.value;
      ich_r  <= in_data.in_channel;
    end
    ok_r     <= vld_r[raddr];
    p1_idx_r <= cmd.rd_idx;
    p2_idx_r <= p1_idx_r;
    prod_r   <= coef * samp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      if (cmd.coef_wr) begin
        vld_r[waddr] <= 1'b1;
      end
      p1_vld_r <= cmd.rd_en;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_OUT_CHANNELS; i++) begin
      if (!rst_n || cmd.acc_clr) begin
        acc_r[i] <= '0;
      end else if (p2_vld_r && (p2_idx_r[OUT_IDX_W-1:0] == OUT_IDX_W'(i))) begin
        acc_r[i] <= acc_r[i] + ACC_W'(prod_r);
      end
    end
  end

  // floor shift then saturate
  assign sel = acc_r[cmd.emit_idx[OUT_IDX_W-1:0]];
  assign shr = sel >>> COEF_FRAC;

  always_comb begin
    priority if (shr > SAT_HI) begin
      sat = VAL_W'(SAT_HI);
    end else if (shr < SAT_LO) begin
      sat = VAL_W'(SAT_LO);
    end else begin
      sat = VAL_W'(shr);
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      out_r.result_channel <= cmd.emit_idx;
      out_r.result_value   <= sat;
      out_r.last           <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== design/spatial_filter_matrix_mix.sv =====
// spatial filter matrix mixer: a coefficient load or an ignored sample is taken without stalling
// the input; a sample stalls the input while one shared multiply-accumulate visits each
// used output channel through a 3-stage ram, multiply, add pipeline and then drains
// after a sample on the last used input channel the input also stays stalled while its
// results are emitted, one per used output channel, one per cycle while not stalled
// synchronous active-low reset clears control, accumulators and coefficient valid bits
`default_nettype none

module spatial_filter_matrix_mix import sfm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data
);

  sfm_cmd_t cmd;
  sfm_sts_t sts;

  sfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/sfm_chk.sv =====
// port-level checker for the spatial filter matrix mixer, bound to the top level
// depends on sfm_pkg
`default_nettype none

module sfm_chk import sfm_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_data
);

  logic out_acc;
  assign out_acc = out_valid && !out_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_next_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_data.last |=> out_valid &&
      (out_data.result_channel == CH_W'($past(out_data.result_channel) + CH_W'(1))))
    else $error("output channels not consecutive within a vector");

  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input taken while a vector is being emitted");

  a_vec_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_data.last |=> !out_valid || (out_data.result_channel == '0))
    else $error("new vector does not start at channel 0");

endmodule

bind spatial_filter_matrix_mix sfm_chk u_sfm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
